### design/csc_pkg.sv
// Shared types and constants of the colour space converter.
// Used by csc_div and color_space_converter; no dependencies.
`default_nettype none

package csc_pkg;

	// space codes, register indexes
	localparam logic [2:0] SP_RGB    = 3'd0;
	localparam logic [2:0] SP_HSL    = 3'd1;
	localparam logic [2:0] SP_HSV    = 3'd2;
	localparam logic [2:0] SP_YCC601 = 3'd3;
	localparam logic [2:0] SP_YCC709 = 3'd4;
	localparam logic [2:0] SP_YCOCG  = 3'd5;
	localparam logic [2:0] SP_CMY    = 3'd6;

	localparam int          IDX_W   = 2;
	localparam logic [1:0]  REG_SRC = 2'd0;
	localparam logic [1:0]  REG_TGT = 2'd1;

	// Q16 luma weights
	localparam logic [15:0] Q601_YR = 16'd19595;
	localparam logic [15:0] Q601_YG = 16'd38470;
	localparam logic [15:0] Q601_YB = 16'd7471;
	localparam logic [15:0] Q709_YR = 16'd13933;
	localparam logic [15:0] Q709_YG = 16'd46871;
	localparam logic [15:0] Q709_YB = 16'd4732;
	// Q16 forward chroma scales
	localparam logic [16:0] Q601_ICB = 17'd36984;
	localparam logic [16:0] Q601_ICR = 17'd46745;
	localparam logic [16:0] Q709_ICB = 17'd35318;
	localparam logic [16:0] Q709_ICR = 17'd41615;
	// Q16 inverse coefficients (chroma carried doubled, so result is Q17)
	localparam logic [16:0] Q601_R_CR = 17'd91881;
	localparam logic [16:0] Q601_G_CB = 17'd22553;
	localparam logic [16:0] Q601_G_CR = 17'd46802;
	localparam logic [16:0] Q601_B_CB = 17'd116130;
	localparam logic [16:0] Q709_R_CR = 17'd103206;
	localparam logic [16:0] Q709_G_CB = 17'd12276;
	localparam logic [16:0] Q709_G_CR = 17'd30679;
	localparam logic [16:0] Q709_B_CB = 17'd121609;

	// x / 21675 as (x * HDEN_RECIP) >> HDEN_SH, exact for x < 2^23
	localparam longint      HDEN       = 21675;
	localparam int          HDEN_SH    = 38;
	localparam logic [23:0] HDEN_RECIP = 24'(((64'd1 << HDEN_SH) + HDEN - 1) / HDEN);

	// pipelined restoring divider
	localparam int DIV_QW = 9;   // quotient bits, one per stage
	localparam int DIV_NW = 20;  // numerator bits
	localparam int DIV_DW = 12;  // denominator bits

	localparam int NUM_STAGES = 9 + DIV_QW;

	typedef struct packed {
		logic [7:0] d0;
		logic [7:0] d1;
		logic [7:0] d2;
		logic       zero;   // grey pixel: hue and saturation forced to 0
		logic       last;
	} csc_pay_t;

endpackage

`default_nettype wire

### design/csc_div.sv
// Two-lane pipelined restoring divider, one quotient bit per stage.
// Depends on csc_pkg; stage enables come from the top level.
`default_nettype none

module csc_div (
	input  wire logic                              clk,
	input  wire logic [csc_pkg::DIV_QW-1:0]        en,
	input  wire logic [csc_pkg::DIV_NW-1:0]        num_a,
	input  wire logic [csc_pkg::DIV_DW-1:0]        den_a,
	input  wire logic [csc_pkg::DIV_NW-1:0]        num_b,
	input  wire logic [csc_pkg::DIV_DW-1:0]        den_b,
	input  wire csc_pkg::csc_pay_t                 pay_in,
	output      logic [csc_pkg::DIV_QW-1:0]        q_a,
	output      logic [csc_pkg::DIV_QW-1:0]        q_b,
	output      csc_pkg::csc_pay_t                 pay_out
);

	localparam int QW = csc_pkg::DIV_QW;
	localparam int NW = csc_pkg::DIV_NW;
	localparam int DW = csc_pkg::DIV_DW;
	localparam int TW = DW + QW;

	logic [NW-1:0]     rem_a_s [QW];
	logic [NW-1:0]     rem_b_s [QW];
	logic [DW-1:0]     den_a_s [QW];
	logic [DW-1:0]     den_b_s [QW];
	logic [QW-1:0]     quo_a_s [QW];
	logic [QW-1:0]     quo_b_s [QW];
	csc_pkg::csc_pay_t pay_s   [QW];

	for (genvar i = 0; i < QW; i++) begin : g_st
		localparam int SH = QW - 1 - i;
		logic [NW-1:0]     ra, rb;
		logic [DW-1:0]     da, db;
		logic [QW-1:0]     qa, qb, qa_n, qb_n;
		csc_pkg::csc_pay_t p;
		logic [TW-1:0]     ta, tb;
		logic              ga, gb;

		if (i == 0) begin : g_head
			assign ra = num_a;
			assign rb = num_b;
			assign da = den_a;
			assign db = den_b;
			assign qa = '0;
			assign qb = '0;
			assign p  = pay_in;
		end else begin : g_body
			assign ra = rem_a_s[i-1];
			assign rb = rem_b_s[i-1];
			assign da = den_a_s[i-1];
			assign db = den_b_s[i-1];
			assign qa = quo_a_s[i-1];
			assign qb = quo_b_s[i-1];
			assign p  = pay_s[i-1];
		end

		assign ta = TW'(da) << SH;
		assign tb = TW'(db) << SH;
		assign ga = TW'(ra) >= ta;
		assign gb = TW'(rb) >= tb;

		always_comb begin
			qa_n     = qa;
			qb_n     = qb;
			qa_n[SH] = ga;
			qb_n[SH] = gb;
		end

		always_ff @(posedge clk) begin
			if (en[i]) begin
				rem_a_s[i] <= ga ? NW'(TW'(ra) - ta) : ra;
				rem_b_s[i] <= gb ? NW'(TW'(rb) - tb) : rb;
				den_a_s[i] <= da;
				den_b_s[i] <= db;
				quo_a_s[i] <= qa_n;
				quo_b_s[i] <= qb_n;
				pay_s[i]   <= p;
			end
		end
	end

	assign q_a     = quo_a_s[QW-1];
	assign q_b     = quo_b_s[QW-1];
	assign pay_out = pay_s[QW-1];

endmodule

`default_nettype wire

### design/color_space_converter.sv
// Colour space converter top level: source space -> RGB -> target space.
// Depends on csc_pkg and csc_div.
`default_nettype none

// Channel   Dir  Handshake             Contents
// s_*       in   s_tvalid / s_tready   tdata: chan_first, chan_second, chan_third; tlast: in_last
// m_*       out  m_tvalid / m_tready   tdata: res_first, res_second, res_third; tlast: out_last
// cfg_*     in   cfg_valid / cfg_ready index 0 source_space, 1 target_space
//
// One pixel per clock, sustained while m_tready stays high. A request passes through
// 8 stages of arithmetic plus the 9-step restoring divider for hue and saturation,
// plus the output register.
// Reset clears the stage valid bits and both space registers (RGB to RGB).
// A stage holds only while it is full and the stage after it holds, so bubbles close up during a
// stall and nothing is dropped or repeated.

module color_space_converter (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       s_tvalid,
	output      logic                       s_tready,
	input  wire logic [23:0]                s_tdata,   // chan_first, chan_second, chan_third
	input  wire logic                       s_tlast,   // in_last
	output      logic                       m_tvalid,
	input  wire logic                       m_tready,
	output      logic [23:0]                m_tdata,   // res_first, res_second, res_third
	output      logic                       m_tlast,   // out_last
	input  wire logic                       cfg_valid,
	output      logic                       cfg_ready,
	input  wire logic [csc_pkg::IDX_W-1:0]  cfg_index,
	input  wire logic [2:0]                 cfg_data
);

	localparam int NS = csc_pkg::NUM_STAGES;
	localparam int QW = csc_pkg::DIV_QW;

	// ---------------- helpers
	function automatic logic [7:0] clamp8(input logic signed [27:0] v);
		logic [7:0] r;
		if (v < 0)
			r = 8'd0;
		else if (v > 28'sd255)
			r = 8'd255;
		else
			r = v[7:0];
		return r;
	endfunction

	function automatic logic [22:0] hsl_v(input logic [8:0] t, input logic [15:0] pn,
	                                      input logic [15:0] qn);
		logic [22:0] p85, q85, r;
		logic [15:0] dq;
		logic [8:0]  tt;
		p85 = 23'(pn) * 23'd85;
		q85 = 23'(qn) * 23'd85;
		dq  = qn - pn;
		tt  = (t < 9'd85) ? t : 9'(9'd340 - t);
		if (t < 9'd85 || (t >= 9'd255 && t < 9'd340))
			r = p85 + 23'(dq) * 23'(tt);
		else if (t < 9'd255)
			r = q85;
		else
			r = p85;
		return r;
	endfunction

	// ---------------- configuration
	logic [2:0] src_q, tgt_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_q <= csc_pkg::SP_RGB;
			tgt_q <= csc_pkg::SP_RGB;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				csc_pkg::REG_SRC: src_q <= cfg_data;
				csc_pkg::REG_TGT: tgt_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// ---------------- stage control
	logic [NS:1]   vld_q;
	logic [NS:1]   vin;
	logic [NS+1:1] en;

	always_comb begin
		en[NS+1] = m_tready;
		for (int k = NS; k >= 1; k--)
			en[k] = !vld_q[k] || en[k+1];
	end

	assign vin      = {vld_q[NS-1:1], s_tvalid};
	assign s_tready = en[1];
	assign m_tvalid = vld_q[NS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= '0;
		else
			for (int k = 1; k <= NS; k++)
				if (en[k])
					vld_q[k] <= vin[k];
	end

	// ---------------- S1: request in, inverse products
	logic [7:0]         ia, ib, ic;
	logic               s6_in;
	logic [16:0]        k_rcr, k_gcb, k_gcr, k_bcb;
	logic signed [9:0]  cbv, crv;
	logic [8:0]         h_c;
	logic [2:0]         hk_c, hreg_c;
	logic [6:0]         hf_c;

	assign ia    = s_tdata[7:0];
	assign ib    = s_tdata[15:8];
	assign ic    = s_tdata[23:16];
	assign s6_in = (src_q == csc_pkg::SP_YCC601);
	assign k_rcr = s6_in ? csc_pkg::Q601_R_CR : csc_pkg::Q709_R_CR;
	assign k_gcb = s6_in ? csc_pkg::Q601_G_CB : csc_pkg::Q709_G_CB;
	assign k_gcr = s6_in ? csc_pkg::Q601_G_CR : csc_pkg::Q709_G_CR;
	assign k_bcb = s6_in ? csc_pkg::Q601_B_CB : csc_pkg::Q709_B_CB;
	assign cbv   = $signed({1'b0, ib, 1'b0}) - 10'sd255;
	assign crv   = $signed({1'b0, ic, 1'b0}) - 10'sd255;
	assign h_c   = {ia, 1'b0};

	// hue sector: k = h / 85, region uses closed upper bounds
	always_comb begin
		hk_c = 3'(h_c >= 9'd85) + 3'(h_c >= 9'd170) + 3'(h_c >= 9'd255)
		     + 3'(h_c >= 9'd340) + 3'(h_c >= 9'd425) + 3'(h_c >= 9'd510);
		hf_c = 7'(h_c - 9'(hk_c * 9'd85));
		hreg_c = 3'(h_c > 9'd85) + 3'(h_c > 9'd170) + 3'(h_c > 9'd255)
		       + 3'(h_c > 9'd340) + 3'(h_c > 9'd425);
	end

	logic [7:0]         a_s1, b_s1, c_s1;
	logic               last_s1;
	logic [15:0]        cbp_s1;
	logic signed [27:0] pr_s1, pgb_s1, pgr_s1, pbb_s1;
	logic [6:0]         xf_s1;
	logic [2:0]         hreg_s1;
	logic [8:0]         h_s1;

	always_ff @(posedge clk) begin
		if (en[1]) begin
			a_s1    <= ia;
			b_s1    <= ib;
			c_s1    <= ic;
			last_s1 <= s_tlast;
			cbp_s1  <= 16'(ic) * 16'(ib);
			pr_s1   <= $signed({1'b0, k_rcr}) * crv;
			pgb_s1  <= $signed({1'b0, k_gcb}) * cbv;
			pgr_s1  <= $signed({1'b0, k_gcr}) * crv;
			pbb_s1  <= $signed({1'b0, k_bcb}) * cbv;
			xf_s1   <= hk_c[0] ? 7'(7'd85 - hf_c) : hf_c;
			hreg_s1 <= hreg_c;
			h_s1    <= h_c;
		end
	end

	// ---------------- S2: direct spaces, HSL p/q, HSV numerators
	logic signed [27:0] as28, bs28, cs28, y17;
	logic [7:0]         dir2_c [3];
	logic [16:0]        c255, qn_c, pn_c;
	logic [8:0]         t_c [3];
	logic [22:0]        cn_c, xn_c, mn_c;
	logic [22:0]        hv_c [3];

	assign as28 = $signed({20'b0, a_s1});
	assign bs28 = $signed({20'b0, b_s1});
	assign cs28 = $signed({20'b0, c_s1});
	assign y17  = $signed({3'b0, a_s1, 17'b0});

	always_comb begin
		unique case (src_q)
			csc_pkg::SP_YCC601, csc_pkg::SP_YCC709: begin
				dir2_c[0] = clamp8((y17 + pr_s1) >>> 17);
				dir2_c[1] = clamp8((y17 - pgb_s1 - pgr_s1) >>> 17);
				dir2_c[2] = clamp8((y17 + pbb_s1) >>> 17);
			end
			csc_pkg::SP_YCOCG: begin
				dir2_c[0] = clamp8(as28 + bs28 - cs28);
				dir2_c[1] = clamp8((28'sd2 * as28 + 28'sd2 * cs28 - 28'sd255) >>> 1);
				dir2_c[2] = clamp8(as28 - bs28 - cs28 + 28'sd255);
			end
			csc_pkg::SP_CMY: begin
				dir2_c[0] = 8'd255 - a_s1;
				dir2_c[1] = 8'd255 - b_s1;
				dir2_c[2] = 8'd255 - c_s1;
			end
			default: begin
				dir2_c[0] = a_s1;
				dir2_c[1] = b_s1;
				dir2_c[2] = c_s1;
			end
		endcase
	end

	// HSL: qn and pn scaled by 255*255; hue offsets in 1/510 turn
	always_comb begin
		c255 = {1'b0, c_s1, 8'b0} - 17'(c_s1);
		if (c_s1 < 8'd128)
			qn_c = 17'(cbp_s1) + c255;
		else
			qn_c = {1'b0, b_s1, 8'b0} - 17'(b_s1) + c255 - 17'(cbp_s1);
		pn_c   = {c_s1, 9'b0} - 17'(c_s1) - 17'(c_s1) - qn_c;
		t_c[0] = (h_s1 > 9'd340) ? 9'(h_s1 - 9'd340) : 9'(h_s1 + 9'd170);
		t_c[1] = h_s1;
		t_c[2] = (h_s1 < 9'd170) ? 9'(h_s1 + 9'd340) : 9'(h_s1 - 9'd170);
	end

	// HSV: chroma and intermediate scaled by 21675
	always_comb begin
		cn_c = 23'(cbp_s1) * 23'd85;
		xn_c = 23'(cbp_s1) * 23'(xf_s1);
		mn_c = 23'(c_s1) * 23'(csc_pkg::HDEN) - cn_c;
		unique case (hreg_s1)
			3'd0:    begin hv_c[0] = cn_c; hv_c[1] = xn_c; hv_c[2] = '0;   end
			3'd1:    begin hv_c[0] = xn_c; hv_c[1] = cn_c; hv_c[2] = '0;   end
			3'd2:    begin hv_c[0] = '0;   hv_c[1] = cn_c; hv_c[2] = xn_c; end
			3'd3:    begin hv_c[0] = '0;   hv_c[1] = xn_c; hv_c[2] = cn_c; end
			3'd4:    begin hv_c[0] = xn_c; hv_c[1] = '0;   hv_c[2] = cn_c; end
			default: begin hv_c[0] = cn_c; hv_c[1] = '0;   hv_c[2] = xn_c; end
		endcase
		for (int i = 0; i < 3; i++)
			hv_c[i] = hv_c[i] + mn_c;
	end

	logic [7:0]  dir_s2 [3];
	logic [15:0] qn_s2, pn_s2;
	logic [8:0]  t_s2 [3];
	logic [22:0] nv_s2 [3];
	logic        last_s2;

	always_ff @(posedge clk) begin
		if (en[2]) begin
			dir_s2  <= dir2_c;
			qn_s2   <= qn_c[15:0];
			pn_s2   <= pn_c[15:0];
			t_s2    <= t_c;
			nv_s2   <= hv_c;
			last_s2 <= last_s1;
		end
	end

	// ---------------- S3: HSL channel numerators
	logic [22:0] nv_s3 [3];
	logic [7:0]  dir_s3 [3];
	logic        last_s3;

	always_ff @(posedge clk) begin
		if (en[3]) begin
			for (int i = 0; i < 3; i++)
				nv_s3[i] <= (src_q == csc_pkg::SP_HSL) ? hsl_v(t_s2[i], pn_s2, qn_s2)
				                                       : nv_s2[i];
			dir_s3  <= dir_s2;
			last_s3 <= last_s2;
		end
	end

	// ---------------- S4: divide by 21675 via reciprocal
	logic [46:0] prod_s4 [3];
	logic [7:0]  dir_s4 [3];
	logic        last_s4;

	always_ff @(posedge clk) begin
		if (en[4]) begin
			for (int i = 0; i < 3; i++)
				prod_s4[i] <= 47'(nv_s3[i]) * 47'(csc_pkg::HDEN_RECIP);
			dir_s4  <= dir_s3;
			last_s4 <= last_s3;
		end
	end

	// ---------------- S5: RGB
	logic       hue_src;
	logic [8:0] qh_c [3];
	logic [7:0] rgb_s5 [3];
	logic       last_s5;

	assign hue_src = (src_q == csc_pkg::SP_HSL) || (src_q == csc_pkg::SP_HSV);

	always_comb
		for (int i = 0; i < 3; i++)
			qh_c[i] = prod_s4[i][46:csc_pkg::HDEN_SH];

	always_ff @(posedge clk) begin
		if (en[5]) begin
			for (int i = 0; i < 3; i++)
				rgb_s5[i] <= !hue_src ? dir_s4[i] : (qh_c[i][8] ? 8'd255 : qh_c[i][7:0]);
			last_s5 <= last_s4;
		end
	end

	// ---------------- S6: max/min, luma products, direct targets
	logic        s6_out;
	logic [7:0]  r5, g5, b5, mx_c, mn_c6;
	logic [1:0]  hsel_c;
	logic [10:0] co0, co1, co2;
	logic [7:0]  dir6_c [3];

	assign s6_out = (tgt_q == csc_pkg::SP_YCC601);
	assign r5 = rgb_s5[0];
	assign g5 = rgb_s5[1];
	assign b5 = rgb_s5[2];

	always_comb begin
		mx_c  = r5;
		mn_c6 = r5;
		if (g5 > mx_c)  mx_c  = g5;
		if (b5 > mx_c)  mx_c  = b5;
		if (g5 < mn_c6) mn_c6 = g5;
		if (b5 < mn_c6) mn_c6 = b5;
		priority if (r5 == mx_c) hsel_c = 2'd0;
		else if (g5 == mx_c)     hsel_c = 2'd1;
		else                     hsel_c = 2'd2;
		co0 = (11'(r5) + {2'b0, g5, 1'b0} + 11'(b5)) >> 2;
		co1 = (11'(r5) + 11'd255 - 11'(b5)) >> 1;
		co2 = ({2'b0, g5, 1'b0} + 11'd510 - 11'(r5) - 11'(b5)) >> 2;
		unique case (tgt_q)
			csc_pkg::SP_YCOCG: begin
				dir6_c[0] = co0[7:0];
				dir6_c[1] = co1[7:0];
				dir6_c[2] = co2[7:0];
			end
			csc_pkg::SP_CMY: begin
				dir6_c[0] = 8'd255 - r5;
				dir6_c[1] = 8'd255 - g5;
				dir6_c[2] = 8'd255 - b5;
			end
			default: dir6_c = rgb_s5;
		endcase
	end

	logic [7:0]  rgb_s6 [3];
	logic [7:0]  mx_s6, d_s6;
	logic [8:0]  sum_s6;
	logic [1:0]  hsel_s6;
	logic [23:0] yp_s6 [3];
	logic [7:0]  dir_s6 [3];
	logic        last_s6;

	always_ff @(posedge clk) begin
		if (en[6]) begin
			rgb_s6   <= rgb_s5;
			mx_s6    <= mx_c;
			d_s6     <= mx_c - mn_c6;
			sum_s6   <= 9'(mx_c) + 9'(mn_c6);
			hsel_s6  <= hsel_c;
			yp_s6[0] <= 24'(s6_out ? csc_pkg::Q601_YR : csc_pkg::Q709_YR) * 24'(r5);
			yp_s6[1] <= 24'(s6_out ? csc_pkg::Q601_YG : csc_pkg::Q709_YG) * 24'(g5);
			yp_s6[2] <= 24'(s6_out ? csc_pkg::Q601_YB : csc_pkg::Q709_YB) * 24'(b5);
			dir_s6   <= dir6_c;
			last_s6  <= last_s5;
		end
	end

	// ---------------- S7: hue and saturation operands, luma sum
	logic signed [21:0] num_c, n_c;
	logic [7:0]         base_c, lden_c;
	logic [10:0]        den6_c;
	logic [8:0]         sum1_c;
	logic [19:0]        hn_c, sn_c;
	logic [11:0]        hd_c, sd_c;
	logic [7:0]         dir7_c [3];
	logic [24:0]        y16_c;

	always_comb begin
		unique case (hsel_s6)
			2'd0: begin
				num_c  = $signed(22'(rgb_s6[1])) - $signed(22'(rgb_s6[2]));
				base_c = (rgb_s6[1] >= rgb_s6[2]) ? 8'd0 : 8'd255;
			end
			2'd1: begin
				num_c  = $signed(22'(rgb_s6[2])) - $signed(22'(rgb_s6[0]));
				base_c = 8'd85;
			end
			default: begin
				num_c  = $signed(22'(rgb_s6[0])) - $signed(22'(rgb_s6[1]));
				base_c = 8'd170;
			end
		endcase
		den6_c = 11'(d_s6) * 11'd6;
		n_c    = num_c * 22'sd255 + $signed(22'(base_c) * 22'(den6_c));
		hn_c   = 20'(2 * n_c + $signed(22'(den6_c)));
		hd_c   = {den6_c, 1'b0};
		lden_c = (sum_s6 > 9'd255) ? 8'(9'd510 - sum_s6) : sum_s6[7:0];
		sum1_c = 9'((10'(sum_s6) + 10'd1) >> 1);
		if (tgt_q == csc_pkg::SP_HSL) begin
			sn_c = 20'(d_s6) * 20'd510 + 20'(lden_c);
			sd_c = {3'b0, lden_c, 1'b0};
		end else begin
			sn_c = 20'(d_s6) * 20'd510 + 20'(mx_s6);
			sd_c = {3'b0, mx_s6, 1'b0};
		end
		dir7_c = dir_s6;
		if (tgt_q == csc_pkg::SP_HSL)
			dir7_c[2] = sum1_c[7:0];
		else if (tgt_q == csc_pkg::SP_HSV)
			dir7_c[2] = mx_s6;
		y16_c = 25'(yp_s6[0]) + 25'(yp_s6[1]) + 25'(yp_s6[2]);
	end

	logic [19:0]        hn_s7, sn_s7;
	logic [11:0]        hd_s7, sd_s7;
	logic [7:0]         dir_s7 [3];
	logic               zero_s7, last_s7;
	logic [24:0]        y16_s7;
	logic signed [25:0] cbd_s7, crd_s7;

	always_ff @(posedge clk) begin
		if (en[7]) begin
			hn_s7   <= hn_c;
			hd_s7   <= hd_c;
			sn_s7   <= sn_c;
			sd_s7   <= sd_c;
			dir_s7  <= dir7_c;
			zero_s7 <= (d_s6 == 8'd0);
			y16_s7  <= y16_c;
			cbd_s7  <= $signed({2'b0, rgb_s6[2], 16'b0}) - $signed({1'b0, y16_c});
			crd_s7  <= $signed({2'b0, rgb_s6[0], 16'b0}) - $signed({1'b0, y16_c});
			last_s7 <= last_s6;
		end
	end

	// ---------------- S8: chroma scaling (Q32 with offset 127.5)
	localparam logic signed [43:0] CHROMA_HALF = 44'sd255 <<< 31;

	logic [16:0]        icb, icr;
	logic [19:0]        hn_s8, sn_s8;
	logic [11:0]        hd_s8, sd_s8;
	logic [7:0]         dir_s8 [3];
	logic               zero_s8, last_s8;
	logic [7:0]         y8_s8;
	logic signed [43:0] cbm_s8, crm_s8;

	assign icb = s6_out ? csc_pkg::Q601_ICB : csc_pkg::Q709_ICB;
	assign icr = s6_out ? csc_pkg::Q601_ICR : csc_pkg::Q709_ICR;

	always_ff @(posedge clk) begin
		if (en[8]) begin
			hn_s8   <= hn_s7;
			hd_s8   <= hd_s7;
			sn_s8   <= sn_s7;
			sd_s8   <= sd_s7;
			dir_s8  <= dir_s7;
			zero_s8 <= zero_s7;
			y8_s8   <= clamp8($signed(28'(y16_s7 >> 16)));
			cbm_s8  <= cbd_s7 * $signed({1'b0, icb}) + CHROMA_HALF;
			crm_s8  <= crd_s7 * $signed({1'b0, icr}) + CHROMA_HALF;
			last_s8 <= last_s7;
		end
	end

	// ---------------- S9..S17: hue and saturation divider
	csc_pkg::csc_pay_t pay_c, pay_d;
	logic [QW-1:0]     qh, qs;

	always_comb begin
		pay_c.zero = zero_s8;
		pay_c.last = last_s8;
		if (tgt_q == csc_pkg::SP_YCC601 || tgt_q == csc_pkg::SP_YCC709) begin
			pay_c.d0 = y8_s8;
			pay_c.d1 = clamp8(28'(cbm_s8 >>> 32));
			pay_c.d2 = clamp8(28'(crm_s8 >>> 32));
		end else begin
			pay_c.d0 = dir_s8[0];
			pay_c.d1 = dir_s8[1];
			pay_c.d2 = dir_s8[2];
		end
	end

	csc_div u_div (
		.clk     (clk),
		.en      (en[NS-1:NS-QW]),
		.num_a   (hn_s8),
		.den_a   (hd_s8),
		.num_b   (sn_s8),
		.den_b   (sd_s8),
		.pay_in  (pay_c),
		.q_a     (qh),
		.q_b     (qs),
		.pay_out (pay_d)
	);

	// ---------------- S18: output register
	logic       hue_tgt;
	logic [7:0] res_s18 [3];
	logic       last_s18;

	assign hue_tgt = (tgt_q == csc_pkg::SP_HSL) || (tgt_q == csc_pkg::SP_HSV);

	always_ff @(posedge clk) begin
		if (en[NS]) begin
			if (hue_tgt) begin
				res_s18[0] <= pay_d.zero ? 8'd0 : (qh > QW'(255) ? 8'd255 : qh[7:0]);
				res_s18[1] <= pay_d.zero ? 8'd0 : (qs > QW'(255) ? 8'd255 : qs[7:0]);
			end else begin
				res_s18[0] <= pay_d.d0;
				res_s18[1] <= pay_d.d1;
			end
			res_s18[2] <= pay_d.d2;
			last_s18   <= pay_d.last;
		end
	end

	assign m_tdata = {res_s18[2], res_s18[1], res_s18[0]};
	assign m_tlast = last_s18;

	// ---------------- assertions
	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		m_tready |-> s_tready)
		else $error("input stalled while output is taken");

	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(&vld_q && !m_tready) |-> !s_tready)
		else $error("request taken into a full stalled pipeline");

	a_drain_count: assert property (@(posedge clk) disable iff (!arst_n)
		(!(s_tvalid && s_tready) && m_tvalid && m_tready)
		|=> ($countones(vld_q) == $past($countones(vld_q)) - 1))
		else $error("pipeline occupancy lost or duplicated an item");

endmodule

`default_nettype wire

### tb/csc_checker.sv
// Checker for the colour space converter: predicts each pixel from the
// requests seen on s_* and compares the results seen on m_*. Depends on csc_pkg.
module csc_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	input  wire logic        s_tready,
	input  wire logic [23:0] s_tdata,
	input  wire logic        s_tlast,
	input  wire logic        m_tvalid,
	input  wire logic        m_tready,
	input  wire logic [23:0] m_tdata,
	input  wire logic        m_tlast,
	input  wire logic        cfg_valid,
	input  wire logic        cfg_ready,
	input  wire logic [csc_pkg::IDX_W-1:0] cfg_index,
	input  wire logic [2:0]  cfg_data,
	output int               fail_count,
	output int               pending
);

	localparam longint QDEN = 21675;

	logic [2:0] src_sp, tgt_sp;
	logic [24:0] pixel_q[$];

	function automatic longint clamp8(longint v);
		if (v < 0) return 0;
		if (v > 255) return 255;
		return v;
	endfunction

	function automatic longint fix8(longint v, int sh);
		if (v < 0) return 0;
		return clamp8(v >>> sh);
	endfunction

	function automatic longint hsl_part(longint t, longint pn, longint qn);
		longint v;
		if (t < 85) v = pn * 85 + (qn - pn) * t;
		else if (t < 255) v = qn * 85;
		else if (t < 340) v = pn * 85 + (qn - pn) * (340 - t);
		else v = pn * 85;
		return clamp8(v / QDEN);
	endfunction

	function automatic longint hue_byte(longint r, longint g, longint b, longint mx, longint d);
		longint num, base, n, den;
		den = 6 * d;
		if (r == mx) begin
			num = g - b;
			base = (g >= b) ? 0 : 255;
		end else if (g == mx) begin
			num = b - r;
			base = 85;
		end else begin
			num = r - g;
			base = 170;
		end
		n = 255 * num + base * den;
		return clamp8((2 * n + den) / (2 * den));
	endfunction

	// source space -> RGB
	function automatic void decode_rgb(input logic [2:0] sp, inout longint px[3]);
		longint a, b, c, qn, pn, tr, tb, h, k, f, cn, xn, mn, r, g, bl, y, cb, cr, g2;
		longint krcr, kgcb, kgcr, kbcb;
		a = px[0];
		b = px[1];
		c = px[2];
		case (sp)
			csc_pkg::SP_HSL: begin
				qn = (2 * c < 255) ? c * (b + 255) : 255 * (c + b) - c * b;
				pn = 510 * c - qn;
				tr = 2 * a + 170;
				tb = 2 * a - 170;
				if (tr > 510) tr -= 510;
				if (tb < 0) tb += 510;
				px[0] = hsl_part(tr, pn, qn);
				px[1] = hsl_part(2 * a, pn, qn);
				px[2] = hsl_part(tb, pn, qn);
			end
			csc_pkg::SP_HSV: begin
				h = 2 * a;
				k = h / 85;
				f = h % 85;
				cn = c * b * 85;
				xn = c * b * (k[0] ? (85 - f) : f);
				mn = c * QDEN - cn;
				if (h <= 85) begin r = cn; g = xn; bl = 0; end
				else if (h <= 170) begin r = xn; g = cn; bl = 0; end
				else if (h <= 255) begin r = 0; g = cn; bl = xn; end
				else if (h <= 340) begin r = 0; g = xn; bl = cn; end
				else if (h <= 425) begin r = xn; g = 0; bl = cn; end
				else begin r = cn; g = 0; bl = xn; end
				px[0] = clamp8((r + mn) / QDEN);
				px[1] = clamp8((g + mn) / QDEN);
				px[2] = clamp8((bl + mn) / QDEN);
			end
			csc_pkg::SP_YCC601, csc_pkg::SP_YCC709: begin
				y = a * 131072;
				cb = 2 * b - 255;
				cr = 2 * c - 255;
				if (sp == csc_pkg::SP_YCC601) begin
					krcr = csc_pkg::Q601_R_CR;
					kgcb = csc_pkg::Q601_G_CB;
					kgcr = csc_pkg::Q601_G_CR;
					kbcb = csc_pkg::Q601_B_CB;
				end else begin
					krcr = csc_pkg::Q709_R_CR;
					kgcb = csc_pkg::Q709_G_CB;
					kgcr = csc_pkg::Q709_G_CR;
					kbcb = csc_pkg::Q709_B_CB;
				end
				px[0] = fix8(y + krcr * cr, 17);
				px[1] = fix8(y - kgcb * cb - kgcr * cr, 17);
				px[2] = fix8(y + kbcb * cb, 17);
			end
			csc_pkg::SP_YCOCG: begin
				g2 = 2 * a + 2 * c - 255;
				px[0] = clamp8(a + b - c);
				px[1] = (g2 < 0) ? 0 : clamp8(g2 / 2);
				px[2] = clamp8(a - b - c + 255);
			end
			csc_pkg::SP_CMY: begin
				px[0] = 255 - a;
				px[1] = 255 - b;
				px[2] = 255 - c;
			end
			default: ;
		endcase
	endfunction

	// RGB -> target space
	function automatic void encode_rgb(input logic [2:0] sp, inout longint px[3]);
		longint r, g, b, mx, mn, d, sum, den, y16, half, wr, wg, wb, icb, icr;
		r = px[0];
		g = px[1];
		b = px[2];
		mx = r; mn = r;
		if (g > mx) mx = g;
		if (b > mx) mx = b;
		if (g < mn) mn = g;
		if (b < mn) mn = b;
		d = mx - mn;
		case (sp)
			csc_pkg::SP_HSL: begin
				sum = mx + mn;
				den = 255 - ((sum > 255) ? sum - 255 : 255 - sum);
				px[0] = (d == 0) ? 0 : hue_byte(r, g, b, mx, d);
				px[1] = (d == 0 || den <= 0) ? 0 : clamp8((2 * d * 255 + den) / (2 * den));
				px[2] = (sum + 1) / 2;
			end
			csc_pkg::SP_HSV: begin
				px[0] = (d == 0) ? 0 : hue_byte(r, g, b, mx, d);
				px[1] = (mx == 0) ? 0 : clamp8((2 * d * 255 + mx) / (2 * mx));
				px[2] = mx;
			end
			csc_pkg::SP_YCC601, csc_pkg::SP_YCC709: begin
				if (sp == csc_pkg::SP_YCC601) begin
					wr = csc_pkg::Q601_YR;
					wg = csc_pkg::Q601_YG;
					wb = csc_pkg::Q601_YB;
					icb = csc_pkg::Q601_ICB;
					icr = csc_pkg::Q601_ICR;
				end else begin
					wr = csc_pkg::Q709_YR;
					wg = csc_pkg::Q709_YG;
					wb = csc_pkg::Q709_YB;
					icb = csc_pkg::Q709_ICB;
					icr = csc_pkg::Q709_ICR;
				end
				y16 = wr * r + wg * g + wb * b;
				half = longint'(255) << 31;
				px[0] = fix8(y16, 16);
				px[1] = fix8((b * 65536 - y16) * icb + half, 32);
				px[2] = fix8((r * 65536 - y16) * icr + half, 32);
			end
			csc_pkg::SP_YCOCG: begin
				px[0] = clamp8((r + 2 * g + b) / 4);
				px[1] = clamp8((r - b + 255) / 2);
				px[2] = clamp8((2 * g - r - b + 510) / 4);
			end
			csc_pkg::SP_CMY: begin
				px[0] = 255 - r;
				px[1] = 255 - g;
				px[2] = 255 - b;
			end
			default: ;
		endcase
	endfunction

	function automatic logic [24:0] convert_pixel(logic [23:0] d, logic last);
		longint px[3];
		px[0] = d[7:0];
		px[1] = d[15:8];
		px[2] = d[23:16];
		decode_rgb(src_sp, px);
		encode_rgb(tgt_sp, px);
		return {last, 8'(clamp8(px[2])), 8'(clamp8(px[1])), 8'(clamp8(px[0]))};
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic [24:0] want, got;
		if (!arst_n) begin
			src_sp <= csc_pkg::SP_RGB;
			tgt_sp <= csc_pkg::SP_RGB;
			fail_count <= 0;
			pending <= 0;
			pixel_q.delete();
		end else begin
			if (s_tvalid && s_tready)
				pixel_q.push_back(convert_pixel(s_tdata, s_tlast));
			if (m_tvalid && m_tready) begin
				got = {m_tlast, m_tdata};
				if (pixel_q.size() == 0) begin
					$display("%0t: result %h with nothing expected", $time, got);
					fail_count <= fail_count + 1;
				end else begin
					want = pixel_q.pop_front();
					if (want !== got) begin
						$display("%0t: mismatch expected last=%b %h/%h/%h actual last=%b %h/%h/%h",
							$time, want[24], want[7:0], want[15:8], want[23:16],
							got[24], got[7:0], got[15:8], got[23:16]);
						fail_count <= fail_count + 1;
					end
				end
			end
			pending <= pixel_q.size();
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == csc_pkg::REG_SRC) src_sp <= cfg_data;
				else if (cfg_index == csc_pkg::REG_TGT) tgt_sp <= cfg_data;
			end
		end
	end

endmodule

### tb/tb_top.sv
// Testbench top for color_space_converter: drives pixel requests, space
// settings and output stalls; the verdict comes from csc_checker. Depends on csc_pkg.
module tb_top;

	localparam int LATENCY   = 18;
	localparam int IDLE_LIMIT = 2000;   // cycles with no handshake at all

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0, s_tready, s_tlast = 1'b0;
	logic [23:0] s_tdata = '0;
	logic m_tvalid, m_tready = 1'b0, m_tlast;
	logic [23:0] m_tdata;
	logic cfg_valid = 1'b0, cfg_ready;
	logic [csc_pkg::IDX_W-1:0] cfg_index = '0;
	logic [2:0] cfg_data = '0;
	int fail_count, pending;
	bit calm = 1'b0;    // final stretch: no idling on either side
	int quiet = 0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	color_space_converter uut (.*);

	csc_checker chk (.*);

	// receiver: random stall bursts, steady ready in the final stretch
	always @(posedge clk) begin
		int burst;
		if (calm) m_tready <= 1'b1;
		else if (burst > 0) begin
			burst--;
			m_tready <= 1'b0;
		end else if ($urandom_range(0, 5) == 0) begin
			burst = $urandom_range(1, 12) - 1;
			m_tready <= 1'b0;
		end else m_tready <= 1'b1;
	end

	// watchdog on handshakes
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			quiet <= 0;
		else quiet <= quiet + 1;
		if (quiet >= IDLE_LIMIT) begin
			$display("tb_top: errors");
			$finish;
		end
	end

	// one pixel request; the sender may idle before it
	task automatic send_pixel(input logic [23:0] d, input logic last);
		if (!calm && $urandom_range(0, 7) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		s_tdata <= d;
		s_tlast <= last;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
	endtask

	// input stops, then wait for every outstanding result
	task automatic drain();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	// register writes only once the pipe is empty
	task automatic set_spaces(input logic [2:0] src, input logic [2:0] tgt);
		drain();
		repeat (LATENCY + 2) @(posedge clk);
		cfg_index <= csc_pkg::REG_SRC;
		cfg_data <= src;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_index <= csc_pkg::REG_TGT;
		cfg_data <= tgt;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [23:0] rand_pixel();
		case ($urandom_range(0, 5))
			0: return {8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
				8'($urandom_range(0, 255))};
			1: begin
				logic [7:0] v;
				v = $urandom_range(0, 255);
				return {v, v, v};    // grey
			end
			2: return {8'($urandom_range(0, 1) * 255), 8'($urandom_range(0, 1) * 255),
				8'($urandom_range(0, 1) * 255)};
			default: return 24'($urandom());
		endcase
	endfunction

	initial begin
		logic [23:0] corners[12];
		int n;
		corners = '{24'h000000, 24'hFFFFFF, 24'h0000FF, 24'h00FF00, 24'hFF0000,
			24'h808080, 24'h7F8081, 24'hFF00FF, 24'h01FE7F, 24'hAA5500,
			24'h55AAFF, 24'hFFFF00};
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: corner pixels through every source space, into RGB (CMY for an RGB source)
		for (int sp = 0; sp < 7; sp++) begin
			set_spaces(3'(sp), 3'(sp == 0 ? 6 : 0));
			for (int i = 0; i < 3; i++) send_pixel(corners[(sp * 3 + i) % 12], i[0]);
		end
		set_spaces(csc_pkg::SP_RGB, csc_pkg::SP_HSL);
		send_pixel(24'h404040, 1'b1);    // grey: hue and saturation zero
		set_spaces(csc_pkg::SP_RGB, csc_pkg::SP_HSV);
		send_pixel(24'h000000, 1'b0);    // black: saturation zero
		set_spaces(3'd7, 3'd7);          // unused code passes through
		send_pixel(24'hA5C3E1, 1'b1);

		// random phases, every space pairing reachable, extremes included
		n = 0;
		while (n < 550) begin
			int len;
			if (n > 450) calm = 1'b1;
			if (!calm) set_spaces(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)));
			len = $urandom_range(10, 40);
			for (int i = 0; i < len; i++) begin
				send_pixel(rand_pixel(), 1'($urandom_range(0, 1)));
				n++;
			end
			// phases that end with 201 to 249 pixels sent: hold off until every result is back
			if (n > 200 && n < 250) drain();
		end

		drain();
		repeat (LATENCY + 4) @(posedge clk);
		if (fail_count == 0) $display("tb_top: clean");
		else $display("tb_top: errors");
		$finish;
	end

endmodule

### filelist.f
design/csc_pkg.sv
design/csc_div.sv
design/color_space_converter.sv
tb/csc_checker.sv
tb/tb_top.sv
